[sv/ucfp_pkg.sv]
// shared types and constants for the uart command frame parser
// used by ucfp_regs, ucfp_parse and uart_command_frame_parser_top
package ucfp_pkg;

  // frame sync bytes
  localparam logic [7:0] SYNC0 = 8'd30;
  localparam logic [7:0] SYNC1 = 8'd29;
  localparam logic [7:0] SYNC2 = 8'd28;

  // frame position at which each command's frame is complete
  localparam logic [6:0] HID_END  = 7'd36;
  localparam logic [6:0] LONG_END = 7'd68;
  localparam logic [6:0] BATT_END = 7'd8;

  // first payload position and last header position
  localparam logic [6:0] POS_CMD     = 7'd3;
  localparam logic [6:0] POS_PAYLOAD = 7'd4;

  // register reset values
  localparam logic [7:0]  HID_CODE_RST   = 8'd1;
  localparam logic [7:0]  WEBUSB_CODE_RST = 8'd2;
  localparam logic [7:0]  BATT_CODE_RST  = 8'd3;
  localparam logic [31:0] BATT_THR_RST   = 32'd0;
  localparam logic        BATT_EN_RST    = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_HID_CODE    = 3'd0;
  localparam logic [2:0] REG_WEBUSB_CODE = 3'd1;
  localparam logic [2:0] REG_BATT_CODE   = 3'd2;
  localparam logic [2:0] REG_BATT_THR    = 3'd3;
  localparam logic [2:0] REG_BATT_EN     = 3'd4;

  // result kinds
  typedef enum logic [2:0] {
    KIND_CONSUMED = 3'd0,
    KIND_LOG      = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_HID      = 3'd3,
    KIND_BATTERY  = 3'd4
  } kind_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]  hid_code;
    logic [7:0]  webusb_code;
    logic [7:0]  battery_code;
    logic [31:0] battery_threshold;
    logic        battery_check_enable;
  } cfg_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [5:0]  payload_index;
    logic        frame_last;
    logic        battery_low;
    logic        battery_low_first;
  } res_t;

endpackage

[sv/ucfp_regs.sv]
// apb configuration registers of the uart command frame parser
// depends on ucfp_pkg for register indexes, reset values and cfg_t
module ucfp_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output ucfp_pkg::cfg_t   cfg
);

  ucfp_pkg::cfg_t cfg_r;
  ucfp_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        ucfp_pkg::REG_HID_CODE:    cfg_nxt.hid_code = pwdata[7:0];
        ucfp_pkg::REG_WEBUSB_CODE: cfg_nxt.webusb_code = pwdata[7:0];
        ucfp_pkg::REG_BATT_CODE:   cfg_nxt.battery_code = pwdata[7:0];
        ucfp_pkg::REG_BATT_THR:    cfg_nxt.battery_threshold = pwdata;
        ucfp_pkg::REG_BATT_EN:     cfg_nxt.battery_check_enable = pwdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hid_code             <= ucfp_pkg::HID_CODE_RST;
      cfg_r.webusb_code          <= ucfp_pkg::WEBUSB_CODE_RST;
      cfg_r.battery_code         <= ucfp_pkg::BATT_CODE_RST;
      cfg_r.battery_threshold    <= ucfp_pkg::BATT_THR_RST;
      cfg_r.battery_check_enable <= ucfp_pkg::BATT_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      ucfp_pkg::REG_HID_CODE:    prdata = {24'd0, cfg_r.hid_code};
      ucfp_pkg::REG_WEBUSB_CODE: prdata = {24'd0, cfg_r.webusb_code};
      ucfp_pkg::REG_BATT_CODE:   prdata = {24'd0, cfg_r.battery_code};
      ucfp_pkg::REG_BATT_THR:    prdata = cfg_r.battery_threshold;
      ucfp_pkg::REG_BATT_EN:     prdata = {31'd0, cfg_r.battery_check_enable};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

[sv/ucfp_parse.sv]
// frame parsing step: position counter, command, battery bytes, sticky low flag
// depends on ucfp_pkg for sync constants, frame lengths, cfg_t and res_t
module ucfp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  input  ucfp_pkg::cfg_t   cfg,
  output ucfp_pkg::res_t   res
);

  logic [6:0]  pos_r, pos_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [23:0] bb_r, bb_nxt;
  logic        low_seen_r, low_seen_nxt;

  logic [6:0]  pos_inc;
  logic [5:0]  idx;
  logic [31:0] level;
  logic        sync_ok;

  assign pos_inc = pos_r + 7'd1;
  assign idx     = pos_r[5:0] - 6'd4;
  assign level   = {rx_byte, bb_nxt};

  // sync byte match for the current header position
  always_comb begin
    case (pos_r[1:0])
      2'd0:    sync_ok = (rx_byte == ucfp_pkg::SYNC0);
      2'd1:    sync_ok = (rx_byte == ucfp_pkg::SYNC1);
      2'd2:    sync_ok = (rx_byte == ucfp_pkg::SYNC2);
      default: sync_ok = 1'b0;
    endcase
  end

  // next state and result for one byte
  always_comb begin
    pos_nxt      = pos_r;
    cmd_nxt      = cmd_r;
    bb_nxt       = bb_r;
    low_seen_nxt = low_seen_r;
    res          = '0;
    res.kind     = ucfp_pkg::KIND_CONSUMED;

    if (pos_r < ucfp_pkg::POS_CMD) begin
      // sync header
      if (sync_ok) begin
        pos_nxt = pos_inc;
      end else begin
        pos_nxt      = 7'd0;
        res.kind     = ucfp_pkg::KIND_LOG;
        res.out_byte = rx_byte;
      end
    end else if (pos_r == ucfp_pkg::POS_CMD) begin
      // command byte range check
      if (rx_byte >= cfg.hid_code && rx_byte <= cfg.battery_code) begin
        cmd_nxt = rx_byte;
        pos_nxt = ucfp_pkg::POS_PAYLOAD;
      end else begin
        pos_nxt      = 7'd0;
        res.kind     = ucfp_pkg::KIND_UNKNOWN;
        res.out_byte = rx_byte;
      end
    end else begin
      // payload byte
      res.payload_index = idx;
      case (idx)
        6'd0:    bb_nxt[7:0]   = rx_byte;
        6'd1:    bb_nxt[15:8]  = rx_byte;
        6'd2:    bb_nxt[23:16] = rx_byte;
        default: bb_nxt        = bb_r;
      endcase
      pos_nxt = pos_inc;
      if (cmd_r == cfg.hid_code) begin
        res.kind     = ucfp_pkg::KIND_HID;
        res.out_byte = rx_byte;
        if (pos_inc >= ucfp_pkg::HID_END) begin
          res.frame_last = 1'b1;
          pos_nxt        = 7'd0;
        end
      end else if (cmd_r == cfg.webusb_code && pos_inc >= ucfp_pkg::LONG_END) begin
        res.frame_last = 1'b1;
        pos_nxt        = 7'd0;
      end else if (cmd_r == cfg.battery_code && pos_inc >= ucfp_pkg::BATT_END) begin
        res.kind       = ucfp_pkg::KIND_BATTERY;
        res.frame_last = 1'b1;
        pos_nxt        = 7'd0;
        if (cfg.battery_check_enable && level < cfg.battery_threshold) begin
          res.battery_low = 1'b1;
          if (!low_seen_r) begin
            res.battery_low_first = 1'b1;
            low_seen_nxt          = 1'b1;
          end
        end
      end else if (pos_inc >= ucfp_pkg::LONG_END) begin
        res.frame_last = 1'b1;
        pos_nxt        = 7'd0;
      end
    end
  end

  // parser state, advanced once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 7'd0;
      cmd_r      <= 8'd0;
      bb_r       <= 24'd0;
      low_seen_r <= 1'b0;
    end else if (step_en) begin
      pos_r      <= pos_nxt;
      cmd_r      <= cmd_nxt;
      bb_r       <= bb_nxt;
      low_seen_r <= low_seen_nxt;
    end
  end

endmodule

[sv/uart_command_frame_parser_top.sv]
// Takes one received serial byte per in_ request and returns exactly one result per byte,
// in order. A byte is accepted every cycle when the output side keeps up; each byte is
// held in an input register, parsed by combinational logic against the frame state and
// written to the output register. The frame position counter and command/battery
// registers close on themselves, which sets the rate of one byte per clock while the
// output side keeps up. When out_tready is low with a result waiting, both registers
// hold and in_tready drops once the input register is full. Configuration registers
// sit on the apb port at byte addresses 0, 4, 8, 12 and 16 and should only be written
// while no bytes are in flight.
// top level: input register, parse stage, output register, config registers
// depends on ucfp_pkg, ucfp_regs and ucfp_parse
module uart_command_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  // byte input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_byte, [13:8] payload_index,
                                   // [14] battery_low, [15] battery_low_first
  output logic [2:0]  out_tuser,   // [2:0] out_kind
  output logic        out_tlast,   // frame_last
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ucfp_pkg::cfg_t cfg;
  ucfp_pkg::res_t res;
  ucfp_pkg::res_t res_r;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       advance;

  assign cfg_pready = 1'b1;

  // configuration registers
  ucfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // parse stage
  ucfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // pipeline handshake
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.frame_last;
  assign out_tdata  = {res_r.battery_low_first, res_r.battery_low,
                       res_r.payload_index, res_r.out_byte};

  // first low detection always comes with a low level
  a_first_implies_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[14])
    else $error("battery_low_first without battery_low");

  // low battery flags only on battery completion
  a_low_only_battery : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tuser == ucfp_pkg::KIND_BATTERY && out_tlast)
    else $error("battery_low outside a battery frame end");

  // frame end never on log or unknown command results
  a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ucfp_pkg::KIND_CONSUMED ||
      out_tuser == ucfp_pkg::KIND_HID || out_tuser == ucfp_pkg::KIND_BATTERY)
    else $error("frame_last on a non-frame result");

  // a held byte stays in the input register until parsed
  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r))
    else $error("input byte lost before parsing");

endmodule

[sim/uart_command_frame_parser_top_tb.sv]
// testbench for uart_command_frame_parser_top: directed and random byte streams
// are checked against a frame parser model kept in this file
// depends on ucfp_pkg and uart_command_frame_parser_top
module uart_command_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_BYTES  = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int REG_SLOTS     = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [13:8] payload_index,
                                   // [14] battery_low, [15] battery_low_first
  logic [2:0]  out_tuser;          // [2:0] out_kind
  logic        out_tlast;          // frame_last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // parser model state and settings
  ucfp_pkg::cfg_t parser_cfg;
  logic [6:0]     frame_pos;
  logic [7:0]     frame_cmd;
  logic [23:0]    battery_lo_bytes;
  logic           low_reported;

  ucfp_pkg::res_t pending_results[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  uart_command_frame_parser_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // parser state after reset
  function automatic void parser_reset();
    parser_cfg.hid_code             = ucfp_pkg::HID_CODE_RST;
    parser_cfg.webusb_code          = ucfp_pkg::WEBUSB_CODE_RST;
    parser_cfg.battery_code         = ucfp_pkg::BATT_CODE_RST;
    parser_cfg.battery_threshold    = ucfp_pkg::BATT_THR_RST;
    parser_cfg.battery_check_enable = ucfp_pkg::BATT_EN_RST;
    frame_pos        = '0;
    frame_cmd        = '0;
    battery_lo_bytes = '0;
    low_reported     = 1'b0;
  endfunction

  // one received byte through the frame parser, returns its result
  function automatic ucfp_pkg::res_t parse_byte(input logic [7:0] c);
    ucfp_pkg::res_t r;
    logic [6:0]  pos;
    logic [5:0]  idx;
    logic [31:0] level;
    r   = '0;
    pos = frame_pos;
    if (pos < ucfp_pkg::POS_CMD) begin
      // sync bytes; a failing byte goes out as log and restarts the search
      if ((pos == 7'd0 && c == ucfp_pkg::SYNC0) || (pos == 7'd1 && c == ucfp_pkg::SYNC1) ||
          (pos == 7'd2 && c == ucfp_pkg::SYNC2)) begin
        pos = pos + 7'd1;
      end else begin
        pos        = '0;
        r.kind     = ucfp_pkg::KIND_LOG;
        r.out_byte = c;
      end
    end else if (pos == ucfp_pkg::POS_CMD) begin
      // command byte must lie in the hid..battery range
      if (c >= parser_cfg.hid_code && c <= parser_cfg.battery_code) begin
        frame_cmd = c;
        pos       = ucfp_pkg::POS_PAYLOAD;
      end else begin
        pos        = '0;
        r.kind     = ucfp_pkg::KIND_UNKNOWN;
        r.out_byte = c;
      end
    end else begin
      // payload byte
      idx = 6'(pos - ucfp_pkg::POS_PAYLOAD);
      r.payload_index = idx;
      if (idx < 6'd3) begin
        battery_lo_bytes[8*idx +: 8] = c;
      end
      pos = pos + 7'd1;
      if (frame_cmd == parser_cfg.hid_code) begin
        r.kind     = ucfp_pkg::KIND_HID;
        r.out_byte = c;
        if (pos >= ucfp_pkg::HID_END) begin
          r.frame_last = 1'b1;
          pos          = '0;
        end
      end else if (frame_cmd == parser_cfg.webusb_code && pos >= ucfp_pkg::LONG_END) begin
        r.frame_last = 1'b1;
        pos          = '0;
      end else if (frame_cmd == parser_cfg.battery_code && pos >= ucfp_pkg::BATT_END) begin
        level        = {c, battery_lo_bytes};
        r.kind       = ucfp_pkg::KIND_BATTERY;
        r.frame_last = 1'b1;
        pos          = '0;
        if (parser_cfg.battery_check_enable && level < parser_cfg.battery_threshold) begin
          r.battery_low = 1'b1;
          if (!low_reported) begin
            r.battery_low_first = 1'b1;
            low_reported        = 1'b1;
          end
        end
      end else if (pos >= ucfp_pkg::LONG_END) begin
        r.frame_last = 1'b1;
        pos          = '0;
      end
    end
    frame_pos = pos;
    return r;
  endfunction

  // result side: random stalls, a long hold when asked, none while steady
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 16);
    end
  end

  // compare each result with the oldest pending one
  always @(posedge clk) begin
    ucfp_pkg::res_t got;
    ucfp_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind              = ucfp_pkg::kind_t'(out_tuser);
      got.out_byte          = out_tdata[7:0];
      got.payload_index     = out_tdata[13:8];
      got.frame_last        = out_tlast;
      got.battery_low       = out_tdata[14];
      got.battery_low_first = out_tdata[15];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: result with none pending: kind=%0d byte=%02h", $realtime,
                   got.kind, got.out_byte);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.out_byte != want.out_byte ||
            got.payload_index != want.payload_index ||
            got.frame_last != want.frame_last || got.battery_low != want.battery_low ||
            got.battery_low_first != want.battery_low_first) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: expected kind=%0d byte=%02h idx=%0d last=%b low=%b first=%b",
                     $realtime, want.kind, want.out_byte, want.payload_index,
                     want.frame_last, want.battery_low, want.battery_low_first);
            $display("%0t:      got kind=%0d byte=%02h idx=%0d last=%b low=%b first=%b",
                     $realtime, got.kind, got.out_byte, got.payload_index,
                     got.frame_last, got.battery_low, got.battery_low_first);
          end
        end
      end
    end
  end

  // send one byte request, with a random one-cycle gap before it
  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(parse_byte(b));
    sent_count++;
    @(negedge clk);
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // apb write, setup then access phase
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      ucfp_pkg::REG_HID_CODE:    parser_cfg.hid_code             = value[7:0];
      ucfp_pkg::REG_WEBUSB_CODE: parser_cfg.webusb_code          = value[7:0];
      ucfp_pkg::REG_BATT_CODE:   parser_cfg.battery_code         = value[7:0];
      ucfp_pkg::REG_BATT_THR:    parser_cfg.battery_threshold    = value;
      ucfp_pkg::REG_BATT_EN:     parser_cfg.battery_check_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] hid, input logic [7:0] webusb,
                            input logic [7:0] battery, input logic [31:0] threshold,
                            input logic enable);
    write_reg(ucfp_pkg::REG_HID_CODE, {24'd0, hid});
    write_reg(ucfp_pkg::REG_WEBUSB_CODE, {24'd0, webusb});
    write_reg(ucfp_pkg::REG_BATT_CODE, {24'd0, battery});
    write_reg(ucfp_pkg::REG_BATT_THR, threshold);
    write_reg(ucfp_pkg::REG_BATT_EN, {31'd0, enable});
  endtask

  // sync, command and, if accepted, the whole payload; first four bytes from head
  task automatic send_frame(input logic [7:0] cmd, input logic [31:0] head);
    int n;
    send_byte(ucfp_pkg::SYNC0);
    send_byte(ucfp_pkg::SYNC1);
    send_byte(ucfp_pkg::SYNC2);
    send_byte(cmd);
    n = 0;
    while (frame_pos >= ucfp_pkg::POS_PAYLOAD) begin
      send_byte(n < 4 ? head[8*n +: 8] : 8'($urandom_range(255)));
      n++;
    end
  endtask

  // log pass-through, broken sync, sync byte not re-examined
  task automatic test_sync_mismatch();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ucfp_pkg::SYNC0);
    send_byte(ucfp_pkg::SYNC1);
    send_byte(8'h1B);
    send_byte(ucfp_pkg::SYNC0);
    send_byte(ucfp_pkg::SYNC0);
    send_byte(ucfp_pkg::SYNC1);
    send_byte(ucfp_pkg::SYNC2);
    wait_idle();
  endtask

  // commands below, above and far outside the valid range
  task automatic test_command_range();
    send_frame(8'h00, '0);
    send_frame(parser_cfg.battery_code + 8'd1, '0);
    send_frame(8'hFF, '0);
    wait_idle();
  endtask

  // hid payload bytes with index and last mark
  task automatic test_hid_frame();
    send_frame(parser_cfg.hid_code, 32'hFF00_FF00);
    send_frame(parser_cfg.hid_code, $urandom());
    wait_idle();
  endtask

  // battery level against threshold, sticky first flag, check disabled
  task automatic test_battery_level();
    write_reg(ucfp_pkg::REG_BATT_THR, 32'h8000_0000);
    send_frame(parser_cfg.battery_code, 32'h7FFF_FFFF);
    send_frame(parser_cfg.battery_code, 32'h0000_0000);
    send_frame(parser_cfg.battery_code, 32'h8000_0000);
    wait_idle();
    write_reg(ucfp_pkg::REG_BATT_EN, 32'd0);
    send_frame(parser_cfg.battery_code, 32'h0000_0000);
    wait_idle();
    write_reg(ucfp_pkg::REG_BATT_EN, 32'd1);
    write_reg(ucfp_pkg::REG_BATT_THR, 32'hFFFF_FFFF);
    send_frame(parser_cfg.battery_code, 32'hFFFF_FFFF);
    send_frame(parser_cfg.battery_code, 32'hFFFF_FFFE);
    wait_idle();
  endtask

  // webusb and other commands take 64 silent bytes, sent with no idling on either side
  task automatic test_long_payloads();
    steady = 1'b1;
    send_frame(parser_cfg.webusb_code, $urandom());
    wait_idle();
    set_config(8'd1, 8'd2, 8'd9, 32'd0, 1'b1);
    send_frame(8'd5, $urandom());
    wait_idle();
    steady = 1'b0;
  endtask

  // coinciding codes and an empty valid range
  task automatic test_shared_codes();
    set_config(8'd7, 8'd7, 8'd7, 32'hFFFF_FFFF, 1'b1);
    send_frame(8'd7, $urandom());
    wait_idle();
    set_config(8'd5, 8'd7, 8'd7, 32'hFFFF_FFFF, 1'b1);
    send_frame(8'd7, $urandom());
    wait_idle();
    set_config(8'd200, 8'd150, 8'd100, 32'hFFFF_FFFF, 1'b1);
    send_frame(8'd150, '0);
    send_frame(8'd200, '0);
    send_frame(8'd100, '0);
    wait_idle();
  endtask

  // writes past the register list change nothing
  task automatic test_unused_registers();
    set_config(ucfp_pkg::HID_CODE_RST, ucfp_pkg::WEBUSB_CODE_RST, ucfp_pkg::BATT_CODE_RST,
               32'h0001_0000, 1'b1);
    for (int i = ucfp_pkg::REG_BATT_EN + 1; i < REG_SLOTS; i++) begin
      write_reg(3'(i), 32'hFFFF_FFFF);
    end
    send_frame(ucfp_pkg::BATT_CODE_RST, 32'h0000_FFFF);
    send_frame(ucfp_pkg::HID_CODE_RST, $urandom());
    wait_idle();
  endtask

  // receiver holds off while frames keep coming, input must stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 2; i++) begin
      send_frame(parser_cfg.hid_code, $urandom());
    end
    wait_idle();
  endtask

  // random frames under the current settings, plus broken sequences and noise
  task automatic random_stream(input int count);
    int          start;
    int          choice;
    logic [7:0]  cmd;
    logic [31:0] head;
    start = sent_count;
    while (sent_count - start < count) begin
      choice = $urandom_range(99);
      if (choice < 70) begin
        case ($urandom_range(3))
          0: cmd = parser_cfg.hid_code;
          1: cmd = parser_cfg.webusb_code;
          2: cmd = parser_cfg.battery_code;
          default: begin
            if (parser_cfg.hid_code <= parser_cfg.battery_code) begin
              cmd = 8'($urandom_range(parser_cfg.battery_code, parser_cfg.hid_code));
            end else begin
              cmd = 8'($urandom_range(255));
            end
          end
        endcase
        // battery levels often right at the threshold
        if ($urandom_range(2) == 0) begin
          head = parser_cfg.battery_threshold + 32'($urandom_range(2)) - 32'd1;
        end else begin
          head = $urandom();
        end
        send_frame(cmd, head);
      end else if (choice < 80) begin
        send_frame(8'($urandom_range(255)), $urandom());
      end else if (choice < 90) begin
        send_byte(ucfp_pkg::SYNC0);
        if ($urandom_range(1)) begin
          send_byte(ucfp_pkg::SYNC1);
        end
        send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // several settings, extremes among them
  task automatic test_random_streams();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    for (int s = 0; s < 7; s++) begin
      a  = 8'($urandom_range(255));
      b  = 8'($urandom_range(255));
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case (s)
        0: set_config(ucfp_pkg::HID_CODE_RST, ucfp_pkg::WEBUSB_CODE_RST,
                      ucfp_pkg::BATT_CODE_RST, 32'd300, 1'b1);
        1: set_config(8'd0, 8'd128, 8'd255, 32'hFFFF_FFFF, 1'b1);
        2: set_config(lo, 8'($urandom_range(hi, lo)), hi, $urandom(), 1'b1);
        3: set_config(8'd255, 8'd255, 8'd255, $urandom(), 1'b0);
        4: set_config(lo, 8'($urandom_range(255)), hi, $urandom(), 1'($urandom_range(1)));
        5: set_config(hi, lo, lo, $urandom(), 1'b1);
        default: set_config(lo, hi, hi, 32'd0, 1'b1);
      endcase
      random_stream(RANDOM_BYTES);
      wait_idle();
    end
  endtask

  initial begin
    parser_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_sync_mismatch();
    test_command_range();
    test_hid_frame();
    test_battery_level();
    test_long_payloads();
    test_shared_codes();
    test_unused_registers();
    test_backpressure();
    test_random_streams();
    wait_idle();
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
sv/ucfp_pkg.sv
sv/ucfp_regs.sv
sv/ucfp_parse.sv
sv/uart_command_frame_parser_top.sv
sim/uart_command_frame_parser_top_tb.sv
